FILE: design/ssf_pkg.sv
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared types and codes for the sensor sample framer: command codes, result
// kinds, fault codes, the job record passed from intake to emission and the
// bank release record passed back.
// ----------------------------------------------------------------------------
package ssf_pkg;

    // input commands; code 3 is ignored
    localparam logic [1:0] CMD_WORD        = 2'd0;
    localparam logic [1:0] CMD_NEW_SESSION = 2'd1;
    localparam logic [1:0] CMD_FRAME_TAKEN = 2'd2;

    // job queue depth between intake and emission (power of two)
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        KD_HEADER = 2'd0,
        KD_VALUE  = 2'd1,
        KD_FAULT  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        FC_NONE   = 2'd0,
        FC_MISSED = 2'd1,
        FC_FULL   = 2'd2
    } t_fault_code;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_LOAD = 2'd2
    } t_back_state;

    // one unit of work for the emission side
    typedef struct packed {
        logic        is_fault;
        logic        bank;
        t_fault_code fault_code;
        logic [63:0] frame_time;
    } t_job;

    // emission side finished reading a bank
    typedef struct packed {
        logic done;
        logic bank;
    } t_bank_release;

endpackage

FILE: design/ssf_ram.sv
// ----------------------------------------------------------------------------
// ssf_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data (held while read enable is low).
// ----------------------------------------------------------------------------
module ssf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/ssf_queue.sv
// ----------------------------------------------------------------------------
// ssf_queue
// Short job queue between intake and emission.
// ----------------------------------------------------------------------------
module ssf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ssf_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output ssf_pkg::t_job o_job
);
    import ssf_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNTW = $clog2(QDEPTH + 1);

    t_job            r_mem [QDEPTH];
    logic [PW-1:0]   r_wptr, n_wptr;
    logic [PW-1:0]   r_rptr, n_rptr;
    logic [CNTW-1:0] r_count, n_count;

    always_comb begin
        n_wptr  = i_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = i_pop  ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    assign o_full  = (r_count == CNTW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job queue read while empty");

endmodule

FILE: design/ssf_front.sv
// ----------------------------------------------------------------------------
// ssf_front
// Intake: accepts transactions, checks sequence numbers, writes channel words
// into the current bank of the value store and queues frame and fault jobs.
// ----------------------------------------------------------------------------
module ssf_front #(
    parameter int CHANNELS         = 10,
    parameter int SAMPLES_IN_FRAME = 5,
    parameter int FRAME_SLOTS      = 8,
    parameter int FW               = CHANNELS * SAMPLES_IN_FRAME,
    parameter int IW               = (FW > 1) ? $clog2(FW) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [63:0]            i_cfg_wdata,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_command,
    input  logic [63:0]            i_capture_time,
    input  logic [7:0]             i_sequence_number,
    input  logic [15:0]            i_channel_value,
    output logic                   o_push,
    output ssf_pkg::t_job          o_job,
    input  logic                   i_q_full,
    input  ssf_pkg::t_bank_release i_release,
    output logic                   o_ram_we,
    output logic [IW:0]            o_ram_waddr,
    output logic [15:0]            o_ram_wdata
);
    import ssf_pkg::*;

    localparam int WCW = $clog2(FW + 1);
    localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FHW = $clog2(FRAME_SLOTS + 1);

    logic [63:0]    r_time_offset;
    logic [WCW-1:0] r_wc, n_wc;
    logic [CW-1:0]  r_chan, n_chan;
    logic [63:0]    r_first_time, n_first_time;
    logic [7:0]     r_prev_seq, n_prev_seq;
    logic           r_fresh, n_fresh;
    logic           r_stopped, n_stopped;
    logic [FHW-1:0] r_held, n_held;
    logic           r_bank, n_bank;
    logic [1:0]     r_busy, n_busy;

    logic        accept;
    logic        is_word;
    logic        sample_start;
    logic [7:0]  seq_step;
    logic        gap;
    logic        store;
    logic        last_word;
    logic        full_fault;
    logic [63:0] base_time;

    assign o_stall      = i_q_full || r_busy[r_bank];
    assign accept       = i_valid && !o_stall;
    assign is_word      = (i_command == CMD_WORD) && !r_stopped;
    assign sample_start = (r_chan == '0);
    assign seq_step     = i_sequence_number - r_prev_seq;
    assign gap          = is_word && sample_start && !r_fresh && (seq_step != 8'd1);
    assign store        = is_word && !gap;
    assign last_word    = store && (r_wc == WCW'(FW - 1));
    assign full_fault   = last_word && (r_held == FHW'(FRAME_SLOTS));
    assign base_time    = (r_wc == '0) ? i_capture_time : r_first_time;

    // job record and value store write
    always_comb begin
        o_push           = accept && (gap || last_word);
        o_job.is_fault   = gap || full_fault;
        o_job.bank       = r_bank;
        o_job.fault_code = gap ? FC_MISSED : (full_fault ? FC_FULL : FC_NONE);
        o_job.frame_time = base_time + r_time_offset;
        o_ram_we         = accept && store;
        o_ram_waddr      = {r_bank, r_wc[IW-1:0]};
        o_ram_wdata      = i_channel_value;
    end

    // state update
    always_comb begin
        n_wc         = r_wc;
        n_chan       = r_chan;
        n_first_time = r_first_time;
        n_prev_seq   = r_prev_seq;
        n_fresh      = r_fresh;
        n_stopped    = r_stopped;
        n_held       = r_held;
        n_bank       = r_bank;
        n_busy       = r_busy;
        if (i_release.done) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (accept) begin
            unique case (i_command)
                CMD_NEW_SESSION: begin
                    n_wc      = '0;
                    n_chan    = '0;
                    n_held    = '0;
                    n_fresh   = 1'b1;
                    n_stopped = 1'b0;
                end
                CMD_FRAME_TAKEN: begin
                    if (r_held != '0) begin
                        n_held = r_held - 1'b1;
                    end
                end
                CMD_WORD: begin
                    if (gap) begin
                        n_stopped = 1'b1;
                    end else if (store) begin
                        if (sample_start) begin
                            n_prev_seq = i_sequence_number;
                            n_fresh    = 1'b0;
                            if (r_wc == '0) begin
                                n_first_time = i_capture_time;
                            end
                        end
                        if (last_word) begin
                            n_wc   = '0;
                            n_chan = '0;
                            if (full_fault) begin
                                n_stopped = 1'b1;
                            end else begin
                                n_held         = r_held + 1'b1;
                                n_bank         = !r_bank;
                                n_busy[r_bank] = 1'b1;
                            end
                        end else begin
                            n_wc   = r_wc + 1'b1;
                            n_chan = (r_chan == CW'(CHANNELS - 1)) ? '0 : r_chan + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_offset <= '0;
            r_wc          <= '0;
            r_chan        <= '0;
            r_first_time  <= '0;
            r_prev_seq    <= '0;
            r_fresh       <= 1'b1;
            r_stopped     <= 1'b0;
            r_held        <= '0;
            r_bank        <= 1'b0;
            r_busy        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_time_offset <= i_cfg_wdata;
            end
            r_wc         <= n_wc;
            r_chan       <= n_chan;
            r_first_time <= n_first_time;
            r_prev_seq   <= n_prev_seq;
            r_fresh      <= n_fresh;
            r_stopped    <= n_stopped;
            r_held       <= n_held;
            r_bank       <= n_bank;
            r_busy       <= n_busy;
        end
    end

    a_wc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wc < WCW'(FW))
        else $error("word count past frame length");

    a_chan_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wc == '0) |-> (r_chan == '0))
        else $error("channel counter out of step with word count");

    a_frame_to_free_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !o_job.is_fault) |=> r_busy[$past(r_bank)])
        else $error("queued frame bank not marked busy");

endmodule

FILE: design/ssf_back.sv
// ----------------------------------------------------------------------------
// ssf_back
// Emission: takes jobs from the queue, sends a fault report or a header and
// the stored channel values through a registered output stage.
// ----------------------------------------------------------------------------
module ssf_back #(
    parameter int FW = 50,
    parameter int IW = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  ssf_pkg::t_job          i_job,
    output logic                   o_pop,
    output logic                   o_ram_re,
    output logic [IW:0]            o_ram_raddr,
    input  logic [15:0]            i_ram_rdata,
    output ssf_pkg::t_bank_release o_release,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [1:0]             o_kind,
    output logic signed [63:0]     o_frame_time,
    output logic [15:0]            o_sample_value,
    output logic [1:0]             o_fault_code,
    output logic                   o_last
);
    import ssf_pkg::*;

    t_back_state r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_bank, n_bank;
    logic          r_out_valid, n_out_valid;
    t_kind         r_kind;
    logic [63:0]   r_time;
    logic [15:0]   r_value;
    t_fault_code   r_code;
    logic          r_last;

    logic slot_free;
    logic load_job;
    logic load_val;
    logic idx_last;

    assign slot_free = !r_out_valid || !i_stall;
    assign idx_last  = (r_idx == IW'(FW - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (i_q_valid && slot_free && !i_job.is_fault) n_state = BK_READ;
            BK_READ: n_state = BK_LOAD;
            BK_LOAD: if (slot_free) n_state = idx_last ? BK_IDLE : BK_READ;
            default: n_state = BK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        load_job       = 1'b0;
        load_val       = 1'b0;
        o_ram_re       = 1'b0;
        o_release.done = 1'b0;
        o_release.bank = r_bank;
        unique case (r_state)
            BK_IDLE: load_job = i_q_valid && slot_free;
            BK_READ: o_ram_re = 1'b1;
            BK_LOAD: begin
                load_val       = slot_free;
                o_release.done = slot_free && idx_last;
            end
            default: begin
            end
        endcase
    end

    assign o_pop       = load_job;
    assign o_ram_raddr = {r_bank, r_idx};

    always_comb begin
        n_idx  = r_idx;
        n_bank = r_bank;
        if (load_job) begin
            n_idx  = '0;
            n_bank = i_job.bank;
        end else if (load_val && !idx_last) begin
            n_idx = r_idx + 1'b1;
        end
        if (load_job || load_val) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_idx       <= '0;
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_bank      <= n_bank;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (load_job) begin
            r_kind  <= i_job.is_fault ? KD_FAULT : KD_HEADER;
            r_time  <= i_job.is_fault ? 64'd0 : i_job.frame_time;
            r_value <= '0;
            r_code  <= i_job.is_fault ? i_job.fault_code : FC_NONE;
            r_last  <= i_job.is_fault;
        end else if (load_val) begin
            r_kind  <= KD_VALUE;
            r_time  <= '0;
            r_value <= i_ram_rdata;
            r_code  <= FC_NONE;
            r_last  <= idx_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_kind;
    assign o_frame_time   = $signed(r_time);
    assign o_sample_value = r_value;
    assign o_fault_code   = r_code;
    assign o_last         = r_last;

endmodule

FILE: design/sensor_sample_framer.sv
// ----------------------------------------------------------------------------
// sensor_sample_framer
// Frames multichannel capacitive sensor samples: sequence check, frame store
// in two banks, header plus channel values per completed frame, fault reports.
// ----------------------------------------------------------------------------
// Order: a header passes through the job queue and then the output register
//   after the last word of a frame is accepted; a fault report likewise after its word.
// Throughput: intake takes one transaction per cycle while o_stall is low;
//   emission sends the header, then reads each channel value from the RAM
//   and loads it, and pops the next job only once the frame has drained.
// Reset: synchronous, active low; clears control state. The value store is
//   not cleared, entries are only read after being written in the frame.
// ----------------------------------------------------------------------------
//
// Structure
//   ssf_front : intake. Accepts every transaction type, tracks word and
//               channel position, checks the sequence number at the start of
//               each sample, holds the frame slot count and the time offset
//               register, writes channel words into the value store.
//   ssf_queue : two-entry job queue. A job is either a fault report or a
//               completed frame (bank plus precomputed frame time).
//   ssf_back  : emission. Pops jobs and drives the registered output stage.
//   ssf_ram   : value store, two banks of one frame each.
//
// Banking: intake fills one bank while emission reads the other. A bank is
// marked busy when its frame is queued and released when its last value is
// loaded into the output register. Intake stalls while the bank it would
// write is busy or the job queue is full, so a slow consumer backs up intake
// only after a whole further frame has been collected.
//
module sensor_sample_framer #(
    parameter int CHANNELS         = 10,
    parameter int SAMPLES_IN_FRAME = 5,
    parameter int FRAME_SLOTS      = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration: time_offset
    input  logic               i_cfg_we,
    input  logic [63:0]        i_cfg_wdata,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_command,
    input  logic [63:0]        i_capture_time,
    input  logic [7:0]         i_sequence_number,
    input  logic [15:0]        i_channel_value,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic signed [63:0] o_frame_time,
    output logic [15:0]        o_sample_value,
    output logic [1:0]         o_fault_code,
    output logic               o_last
);
    import ssf_pkg::*;

    localparam int FW = CHANNELS * SAMPLES_IN_FRAME;
    localparam int IW = (FW > 1) ? $clog2(FW) : 1;
    localparam int RAM_DEPTH = 2 ** (IW + 1);

    logic          push;
    t_job          push_job;
    logic          q_full;
    logic          pop;
    logic          q_valid;
    t_job          head_job;
    t_bank_release release_bank;
    logic          ram_we;
    logic [IW:0]   ram_waddr;
    logic [15:0]   ram_wdata;
    logic          ram_re;
    logic [IW:0]   ram_raddr;
    logic [15:0]   ram_rdata;

    ssf_front #(
        .CHANNELS        (CHANNELS),
        .SAMPLES_IN_FRAME(SAMPLES_IN_FRAME),
        .FRAME_SLOTS     (FRAME_SLOTS),
        .FW              (FW),
        .IW              (IW)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_capture_time   (i_capture_time),
        .i_sequence_number(i_sequence_number),
        .i_channel_value  (i_channel_value),
        .o_push           (push),
        .o_job            (push_job),
        .i_q_full         (q_full),
        .i_release        (release_bank),
        .o_ram_we         (ram_we),
        .o_ram_waddr      (ram_waddr),
        .o_ram_wdata      (ram_wdata)
    );

    ssf_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (push_job),
        .o_full (q_full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_job  (head_job)
    );

    ssf_ram #(
        .WIDTH(16),
        .DEPTH(RAM_DEPTH)
    ) u_value_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    ssf_back #(
        .FW(FW),
        .IW(IW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_job         (head_job),
        .o_pop         (pop),
        .o_ram_re      (ram_re),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata),
        .o_release     (release_bank),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_frame_time  (o_frame_time),
        .o_sample_value(o_sample_value),
        .o_fault_code  (o_fault_code),
        .o_last        (o_last)
    );

endmodule
